### sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Types and constants shared by the serpentine raster tool path block.
// ----------------------------------------------------------------------------
package srt_pkg;

	typedef logic [2:0] class_t;
	typedef logic [1:0] job_code_t;

	localparam class_t CLASS_OTHER = 3'd0;
	localparam class_t CLASS_BLACK = 3'd1;
	localparam class_t CLASS_RED   = 3'd2;
	localparam class_t CLASS_GREEN = 3'd3;
	localparam class_t CLASS_BLUE  = 3'd4;

	localparam job_code_t JOB_UP    = 2'd0;
	localparam job_code_t JOB_DOWN  = 2'd1;
	localparam job_code_t JOB_TRACE = 2'd2;

	localparam logic [2:0] REG_SCAN_VERTICAL = 3'd0;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
	localparam logic [2:0] REG_ORIGIN_X      = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd4;
	localparam logic [2:0] REG_SCALE_CODE    = 3'd5;
	localparam logic [2:0] REG_DEPTH_CODE    = 3'd6;

	localparam logic [10:0] RST_IMAGE_SIDE = 11'd1024;
	localparam logic [13:0] RST_SCALE_CODE = 14'd10000;
	localparam logic [14:0] RST_DEPTH_CODE = 15'd10000;

	localparam logic [14:0]        DEPTH_MAX    = 15'd30000;
	localparam logic [15:0]        PLUNGE_BASE  = 16'd1000;
	localparam logic signed [15:0] Z_UP         = 16'sd20000;
	localparam int                 OFFSET_LIMIT = 1023;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic        scan_vertical;
		logic [10:0] image_width;
		logic [10:0] image_height;
		logic [9:0]  origin_x;
		logic [9:0]  origin_y;
		logic [13:0] scale_code;
		logic [14:0] depth_code;
	} cfg_t;

	typedef struct packed {
		job_code_t          code;
		logic               trace_down;
		logic signed [10:0] offset_x;
		logic signed [10:0] offset_y;
	} job_t;

	function automatic class_t classify(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		class_t c;
		c = CLASS_OTHER;
		if (r == 8'd0 && g == 8'd0 && b == 8'd0) begin
			c = CLASS_BLACK;
		end else if (r == 8'd255 && g == 8'd0 && b == 8'd0) begin
			c = CLASS_RED;
		end else if (r == 8'd0 && g == 8'd255 && b == 8'd0) begin
			c = CLASS_GREEN;
		end else if (r == 8'd0 && g == 8'd0 && b == 8'd255) begin
			c = CLASS_BLUE;
		end
		return c;
	endfunction

endpackage

### sv/srt_front.sv
// ----------------------------------------------------------------------------
// srt_front
// Tracks the serpentine scan position, classifies each pixel and queues the
// records that a class change calls for.
// ----------------------------------------------------------------------------
module srt_front import srt_pkg::*; #(
	parameter int MAX_SIDE = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       pixel_valid,
	output logic       pixel_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       q_full,
	output logic       q_push,
	output job_t       q_job
);

	localparam int IW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int DW = ((IW > 10) ? IW : 10) + 2;

	logic [IW-1:0] step_q;
	logic [IW-1:0] line_q;
	class_t        prev_q;

	logic [SW-1:0]        w;
	logic [SW-1:0]        h;
	logic [SW-1:0]        len;
	logic [SW-1:0]        lines;
	logic                 wrap_in;
	logic [SW-1:0]        step_eff;
	logic [SW-1:0]        line_inc;
	logic [SW-1:0]        line_eff;
	logic [SW-1:0]        step_next;
	logic [SW-1:0]        line_next;
	logic                 reversed;
	logic [SW-1:0]        pos;
	logic [IW-1:0]        px;
	logic [IW-1:0]        py;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [10:0]   ox;
	logic signed [10:0]   oy;
	class_t               cls;
	class_t               prev;
	logic                 has_job;
	logic                 accept;

	always_comb begin
		if (cfg.image_width == 11'd0) begin
			w = SW'(1);
		end else if (32'(cfg.image_width) > 32'(MAX_SIDE)) begin
			w = SW'(MAX_SIDE);
		end else begin
			w = SW'(cfg.image_width);
		end
		if (cfg.image_height == 11'd0) begin
			h = SW'(1);
		end else if (32'(cfg.image_height) > 32'(MAX_SIDE)) begin
			h = SW'(MAX_SIDE);
		end else begin
			h = SW'(cfg.image_height);
		end
		len   = cfg.scan_vertical ? h : w;
		lines = cfg.scan_vertical ? w : h;

		wrap_in  = SW'(step_q) >= len;
		step_eff = wrap_in ? SW'(0) : SW'(step_q);
		line_inc = SW'(line_q) + (wrap_in ? SW'(1) : SW'(0));
		line_eff = (line_inc >= lines) ? SW'(0) : line_inc;

		reversed = line_eff[0];
		pos      = reversed ? (len - SW'(1) - step_eff) : step_eff;
		if (cfg.scan_vertical) begin
			px = IW'(line_eff);
			py = IW'(pos);
		end else begin
			px = IW'(pos);
			py = IW'(line_eff);
		end

		dx = $signed(DW'(px)) - $signed(DW'(cfg.origin_x));
		dy = $signed(DW'(py)) - $signed(DW'(cfg.origin_y));
		if (dx > OFFSET_LIMIT) begin
			ox = 11'(OFFSET_LIMIT);
		end else if (dx < -OFFSET_LIMIT) begin
			ox = -11'(OFFSET_LIMIT);
		end else begin
			ox = dx[10:0];
		end
		if (dy > OFFSET_LIMIT) begin
			oy = 11'(OFFSET_LIMIT);
		end else if (dy < -OFFSET_LIMIT) begin
			oy = -11'(OFFSET_LIMIT);
		end else begin
			oy = dy[10:0];
		end

		cls  = classify(red, green, blue);
		prev = (step_eff == SW'(0)) ? CLASS_OTHER : prev_q;

		q_job.offset_x   = ox;
		q_job.offset_y   = oy;
		q_job.trace_down = 1'b1;
		q_job.code       = JOB_UP;
		has_job          = 1'b0;
		if (cls != prev) begin
			has_job = 1'b1;
			q_job.code = (cls == CLASS_OTHER) ? JOB_UP : JOB_DOWN;
		end else if (cls == CLASS_BLACK) begin
			has_job          = 1'b1;
			q_job.code       = JOB_TRACE;
			q_job.trace_down = ~reversed;
		end

		step_next = step_eff + SW'(1);
		line_next = line_eff;
		if (step_next >= len) begin
			step_next = SW'(0);
			line_next = ((line_eff + SW'(1)) >= lines) ? SW'(0) : (line_eff + SW'(1));
		end
	end

	assign pixel_ready = ~q_full;
	assign accept      = pixel_valid & pixel_ready;
	assign q_push      = accept & has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			line_q <= '0;
			prev_q <= CLASS_OTHER;
		end else if (accept) begin
			step_q <= IW'(step_next);
			line_q <= IW'(line_next);
			prev_q <= cls;
		end
	end

endmodule

### sv/srt_queue.sv
// ----------------------------------------------------------------------------
// srt_queue
// Short first-in first-out queue of record jobs between front and back.
// ----------------------------------------------------------------------------
module srt_queue import srt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t           slots_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full       = count_q == (QAW + 1)'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QAW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QAW + 1)'(1);
			end
		end
	end

endmodule

### sv/srt_back.sv
// ----------------------------------------------------------------------------
// srt_back
// Scales the offsets of each queued job and issues its trace and move
// records through a registered output.
// ----------------------------------------------------------------------------
module srt_back import srt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_valid,
	input  job_t               q_job,
	output logic               q_pop,
	output logic               record_valid,
	input  logic               record_ready,
	output logic               record_kind,
	output logic               tool_down,
	output logic signed [10:0] offset_x,
	output logic signed [10:0] offset_y,
	output logic signed [24:0] move_x,
	output logic signed [24:0] move_y,
	output logic signed [15:0] move_z,
	output logic               last_of_pixel
);

	logic               valid_s1;
	logic               phase_s1;
	job_t               job_s1;
	logic signed [24:0] mx_s1;
	logic signed [24:0] my_s1;
	logic signed [15:0] mz_s1;

	logic               out_valid_q;
	logic               kind_q;
	logic               down_q;
	logic signed [10:0] ox_q;
	logic signed [10:0] oy_q;
	logic signed [24:0] mx_q;
	logic signed [24:0] my_q;
	logic signed [15:0] mz_q;
	logic               last_q;

	logic signed [25:0] prod_x;
	logic signed [25:0] prod_y;
	logic [14:0]        depth;
	logic [15:0]        plunge;
	logic signed [15:0] z_val;
	logic               out_free;
	logic               emit;
	logic               s1_done;
	logic               s1_free;
	logic               is_trace;

	assign prod_x = $signed(q_job.offset_x) * $signed({1'b0, cfg.scale_code});
	assign prod_y = $signed(q_job.offset_y) * $signed({1'b0, cfg.scale_code});
	assign depth  = (cfg.depth_code > DEPTH_MAX) ? DEPTH_MAX : cfg.depth_code;
	assign plunge = PLUNGE_BASE + {1'b0, depth};
	assign z_val  = (q_job.code == JOB_DOWN) ? $signed(16'd0 - plunge) : Z_UP;

	assign out_free = ~out_valid_q | record_ready;
	assign emit     = valid_s1 & out_free;
	assign s1_done  = emit & ((job_s1.code != JOB_DOWN) | phase_s1);
	assign s1_free  = ~valid_s1 | s1_done;
	assign q_pop    = q_valid & s1_free;
	assign is_trace = (job_s1.code == JOB_TRACE) | ((job_s1.code == JOB_DOWN) & ~phase_s1);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_s1 <= q_job;
			mx_s1  <= prod_x[24:0];
			my_s1  <= prod_y[24:0];
			mz_s1  <= z_val;
		end
		if (emit) begin
			kind_q <= ~is_trace;
			ox_q   <= job_s1.offset_x;
			oy_q   <= job_s1.offset_y;
			if (is_trace) begin
				down_q <= job_s1.trace_down;
				mx_q   <= '0;
				my_q   <= '0;
				mz_q   <= '0;
				last_q <= job_s1.code == JOB_TRACE;
			end else begin
				down_q <= job_s1.code == JOB_DOWN;
				mx_q   <= mx_s1;
				my_q   <= my_s1;
				mz_q   <= mz_s1;
				last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
				phase_s1 <= 1'b0;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				phase_s1 <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (record_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign record_valid  = out_valid_q;
	assign record_kind   = kind_q;
	assign tool_down     = down_q;
	assign offset_x      = ox_q;
	assign offset_y      = oy_q;
	assign move_x        = mx_q;
	assign move_y        = my_q;
	assign move_z        = mz_q;
	assign last_of_pixel = last_q;

endmodule

### sv/serpentine_raster_toolpath.sv
// ----------------------------------------------------------------------------
// serpentine_raster_toolpath
// Serpentine raster tool path generator: classifies a stream of RGB pixels
// and turns class changes into tool moves and trace records.
// The first record of a pixel passes the job queue, job stage and output register.
// Throughput: one pixel per cycle while the queue is not full; records leave at
// one per cycle, while record_ready is high, through the single output register.
// Reset clears the scan counters, previous class, job queue and output, and
// returns every configuration register to its default.
// ----------------------------------------------------------------------------
module serpentine_raster_toolpath import srt_pkg::*; #(
	parameter int MAX_SIDE = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               record_valid,
	input  logic               record_ready,
	output logic               record_kind,
	output logic               tool_down,
	output logic signed [10:0] offset_x,
	output logic signed [10:0] offset_y,
	output logic signed [24:0] move_x,
	output logic signed [24:0] move_y,
	output logic signed [15:0] move_z,
	output logic               last_of_pixel
);

	cfg_t       cfg_q;
	logic [2:0] reg_index;
	logic       cfg_write;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_valid;
	job_t       push_job;
	job_t       head_job;

	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_vertical <= 1'b0;
			cfg_q.image_width   <= RST_IMAGE_SIDE;
			cfg_q.image_height  <= RST_IMAGE_SIDE;
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.scale_code    <= RST_SCALE_CODE;
			cfg_q.depth_code    <= RST_DEPTH_CODE;
		end else if (cfg_write) begin
			case (reg_index)
				REG_SCAN_VERTICAL: cfg_q.scan_vertical <= pwdata[0];
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= pwdata[10:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= pwdata[10:0];
				REG_ORIGIN_X:      cfg_q.origin_x      <= pwdata[9:0];
				REG_ORIGIN_Y:      cfg_q.origin_y      <= pwdata[9:0];
				REG_SCALE_CODE:    cfg_q.scale_code    <= pwdata[13:0];
				REG_DEPTH_CODE:    cfg_q.depth_code    <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_SCAN_VERTICAL: prdata = 32'(cfg_q.scan_vertical);
			REG_IMAGE_WIDTH:   prdata = 32'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:  prdata = 32'(cfg_q.image_height);
			REG_ORIGIN_X:      prdata = 32'(cfg_q.origin_x);
			REG_ORIGIN_Y:      prdata = 32'(cfg_q.origin_y);
			REG_SCALE_CODE:    prdata = 32'(cfg_q.scale_code);
			REG_DEPTH_CODE:    prdata = 32'(cfg_q.depth_code);
			default:           prdata = '0;
		endcase
	end

	srt_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	srt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (head_job)
	);

	srt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_job         (head_job),
		.q_pop         (q_pop),
		.record_valid  (record_valid),
		.record_ready  (record_ready),
		.record_kind   (record_kind),
		.tool_down     (tool_down),
		.offset_x      (offset_x),
		.offset_y      (offset_y),
		.move_x        (move_x),
		.move_y        (move_y),
		.move_z        (move_z),
		.last_of_pixel (last_of_pixel)
	);

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serpentine raster tool path block. Pixels are
// streamed in over a valid/ready channel with random gaps, records are taken
// with random back-pressure, and every record is checked field by field against
// an in-bench prediction of the scan counters and pixel classes, or the table's
// own records for typed rows. A short table of directed items comes first;
// random register settings and runs of coloured pixels follow.
// ----------------------------------------------------------------------------
module tb_top import srt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE_LIMIT  = 1024;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES      = 12;
	localparam int PER_PHASE   = 50;

	localparam logic KIND_TRACE = 1'b0;
	localparam logic KIND_MOVE  = 1'b1;
	localparam logic TOOL_UP    = 1'b0;
	localparam logic TOOL_DOWN  = 1'b1;

	localparam logic [23:0] RGB_BLACK = 24'h000000;
	localparam logic [23:0] RGB_RED   = 24'hFF0000;
	localparam logic [23:0] RGB_GREEN = 24'h00FF00;
	localparam logic [23:0] RGB_BLUE  = 24'h0000FF;
	localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;

	typedef struct packed {
		logic               kind;
		logic               down;
		logic signed [10:0] ox;
		logic signed [10:0] oy;
		logic signed [24:0] mx;
		logic signed [24:0] my;
		logic signed [15:0] mz;
		logic               last;
	} rec_t;

	typedef struct packed {
		logic [2:0]  preset;
		logic [23:0] rgb;
		logic        typed;
		logic [1:0]  count;
		rec_t        first;
		rec_t        second;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               pixel_valid = 1'b0;
	logic               pixel_ready;
	logic [7:0]         red = '0;
	logic [7:0]         green = '0;
	logic [7:0]         blue = '0;
	logic               record_valid;
	logic               record_ready = 1'b0;
	logic               record_kind;
	logic               tool_down;
	logic signed [10:0] offset_x;
	logic signed [10:0] offset_y;
	logic signed [24:0] move_x;
	logic signed [24:0] move_y;
	logic signed [15:0] move_z;
	logic               last_of_pixel;

	cfg_t     shadow_cfg;
	class_t   last_class = CLASS_OTHER;
	int       line_no = 0;
	int       step_no = 0;
	rec_t     planned[$];
	rec_t     pending_records[$];
	rec_t     typed_records[$];
	bit       typed_armed = 1'b0;
	dir_row_t dir_rows[$];

	bit          calm = 1'b0;
	int          hold_requests = 0;
	int          holds_served = 0;
	int          gap_odds = 0;
	int          stall_odds = 0;
	int          run_left = 0;
	logic [23:0] run_colour = '0;

	int faults = 0;
	int pixels_taken = 0;
	int records_seen = 0;
	int settings_done = 0;
	int drains = 0;
	int longest_hold = 0;
	int idle_cycles = 0;

	serpentine_raster_toolpath #(.MAX_SIDE(SIDE_LIMIT)) i_dut (.*);

	always #6 clk = ~clk;

	function automatic cfg_t make_cfg(input logic vert, input int w, input int h,
			input int ox, input int oy, input int scale, input int depth);
		cfg_t c;
		c.scan_vertical = vert;
		c.image_width   = 11'(w);
		c.image_height  = 11'(h);
		c.origin_x      = 10'(ox);
		c.origin_y      = 10'(oy);
		c.scale_code    = 14'(scale);
		c.depth_code    = 15'(depth);
		return c;
	endfunction

	function automatic int effective_side(input logic [10:0] v);
		if (v == 11'd0) begin
			return 1;
		end
		if (int'(v) > SIDE_LIMIT) begin
			return SIDE_LIMIT;
		end
		return int'(v);
	endfunction

	function automatic int clip_offset(input int v);
		if (v > OFFSET_LIMIT) begin
			return OFFSET_LIMIT;
		end
		if (v < -OFFSET_LIMIT) begin
			return -OFFSET_LIMIT;
		end
		return v;
	endfunction

	function automatic class_t colour_class(input logic [23:0] rgb);
		case (rgb)
			RGB_BLACK: return CLASS_BLACK;
			RGB_RED:   return CLASS_RED;
			RGB_GREEN: return CLASS_GREEN;
			RGB_BLUE:  return CLASS_BLUE;
			default:   return CLASS_OTHER;
		endcase
	endfunction

	function automatic rec_t shape_record(input logic kind, input logic down, input int ox,
			input int oy, input logic last);
		rec_t rc;
		int   depth;
		depth = (shadow_cfg.depth_code > DEPTH_MAX) ? int'(DEPTH_MAX)
			: int'(shadow_cfg.depth_code);
		rc = '0;
		rc.kind = kind;
		rc.down = down;
		rc.ox   = 11'(ox);
		rc.oy   = 11'(oy);
		rc.last = last;
		if (kind == KIND_MOVE) begin
			rc.mx = 25'(ox * int'(shadow_cfg.scale_code));
			rc.my = 25'(oy * int'(shadow_cfg.scale_code));
			rc.mz = down ? 16'(-(int'(PLUNGE_BASE) + depth)) : Z_UP;
		end
		return rc;
	endfunction

	// Advances the scan position by one pixel and leaves its records in planned.
	function automatic void plan_records(input logic [23:0] rgb);
		int     len;
		int     lines;
		int     pos;
		int     px;
		int     py;
		int     ox;
		int     oy;
		bit     rev;
		class_t c;
		class_t prev;
		planned.delete();
		len   = shadow_cfg.scan_vertical ? effective_side(shadow_cfg.image_height)
			: effective_side(shadow_cfg.image_width);
		lines = shadow_cfg.scan_vertical ? effective_side(shadow_cfg.image_width)
			: effective_side(shadow_cfg.image_height);
		if (step_no >= len) begin
			step_no = 0;
			line_no++;
		end
		if (line_no >= lines) begin
			line_no = 0;
		end
		rev = (line_no % 2) != 0;
		pos = rev ? (len - 1 - step_no) : step_no;
		px  = shadow_cfg.scan_vertical ? line_no : pos;
		py  = shadow_cfg.scan_vertical ? pos : line_no;
		ox  = clip_offset(px - int'(shadow_cfg.origin_x));
		oy  = clip_offset(py - int'(shadow_cfg.origin_y));
		c    = colour_class(rgb);
		prev = (step_no == 0) ? CLASS_OTHER : last_class;
		if (c != prev) begin
			if (c == CLASS_OTHER) begin
				planned.push_back(shape_record(KIND_MOVE, TOOL_UP, ox, oy, 1'b1));
			end else begin
				planned.push_back(shape_record(KIND_TRACE, TOOL_DOWN, ox, oy, 1'b0));
				planned.push_back(shape_record(KIND_MOVE, TOOL_DOWN, ox, oy, 1'b1));
			end
		end else if (c == CLASS_BLACK) begin
			planned.push_back(shape_record(KIND_TRACE, rev ? TOOL_UP : TOOL_DOWN, ox, oy,
				1'b1));
		end
		last_class = c;
		step_no++;
		if (step_no >= len) begin
			step_no = 0;
			line_no++;
			if (line_no >= lines) begin
				line_no = 0;
			end
		end
	endfunction

	function automatic rec_t exp_rec(input logic kind, input logic down, input int ox,
			input int oy, input int mx, input int my, input int mz, input logic last);
		rec_t rc;
		rc.kind = kind;
		rc.down = down;
		rc.ox   = 11'(ox);
		rc.oy   = 11'(oy);
		rc.mx   = 25'(mx);
		rc.my   = 25'(my);
		rc.mz   = 16'(mz);
		rc.last = last;
		return rc;
	endfunction

	function automatic void add_pixel_row(input logic [2:0] preset, input logic [23:0] rgb,
			input logic typed, input int count, input rec_t first, input rec_t second);
		dir_row_t row;
		row.preset = preset;
		row.rgb    = rgb;
		row.typed  = typed;
		row.count  = 2'(count);
		row.first  = first;
		row.second = second;
		dir_rows.push_back(row);
	endfunction

	function automatic cfg_t preset_cfg(input logic [2:0] k);
		case (k)
			3'd1:    return make_cfg(1'b0, 2, 2, 1023, 1023, 16383, 32767);
			3'd2:    return make_cfg(1'b1, 0, 2047, 0, 0, 0, 0);
			3'd3:    return make_cfg(1'b0, 1, 2, 0, 0, 10000, 30000);
			default: return make_cfg(1'b0, 1024, 2, 0, 0, 10000, 30000);
		endcase
	endfunction

	function automatic int random_side();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return $urandom_range(1025, 2047);
			2:       return $urandom_range(9, 64);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		int ox;
		int oy;
		int scale;
		int depth;
		ox = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 8);
		oy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 8);
		case ($urandom_range(0, 7))
			0:       scale = 0;
			1:       scale = 16383;
			default: scale = $urandom_range(1, 10000);
		endcase
		case ($urandom_range(0, 7))
			0:       depth = 0;
			1:       depth = 32767;
			default: depth = $urandom_range(1, 30000);
		endcase
		return make_cfg(1'($urandom_range(0, 1)), random_side(), random_side(), ox, oy,
			scale, depth);
	endfunction

	// Pixels come in runs of one colour so that continued black and repeated
	// classes are common; a share are near misses or fully random.
	function automatic logic [23:0] pick_colour();
		if (run_left == 0) begin
			run_left = $urandom_range(1, 6);
			case ($urandom_range(0, 9))
				0, 1:    run_colour = RGB_BLACK;
				2:       run_colour = RGB_RED;
				3:       run_colour = RGB_GREEN;
				4:       run_colour = RGB_BLUE;
				5:       run_colour = RGB_WHITE;
				6:       run_colour = ($urandom_range(0, 1) ? RGB_RED : RGB_BLACK)
					^ (24'd1 << $urandom_range(0, 23));
				default: run_colour = 24'($urandom);
			endcase
		end
		run_left--;
		return run_colour;
	endfunction

	task automatic flag_mismatch(input string msg);
		faults++;
		if (faults <= 40) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_records.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_when_idle(input cfg_t c);
		wait_drained();
		write_reg(REG_SCAN_VERTICAL, 32'(c.scan_vertical));
		write_reg(REG_IMAGE_WIDTH, 32'(c.image_width));
		write_reg(REG_IMAGE_HEIGHT, 32'(c.image_height));
		write_reg(REG_ORIGIN_X, 32'(c.origin_x));
		write_reg(REG_ORIGIN_Y, 32'(c.origin_y));
		write_reg(REG_SCALE_CODE, 32'(c.scale_code));
		write_reg(REG_DEPTH_CODE, 32'(c.depth_code));
		shadow_cfg = c;
		settings_done++;
	endtask

	task automatic offer_pixel(input logic [23:0] rgb);
		int gap;
		gap = 0;
		if (!calm && gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
			gap = $urandom_range(1, 14);
		end
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		red         <= rgb[23:16];
		green       <= rgb[15:8];
		blue        <= rgb[7:0];
		@(posedge clk);
		while (!pixel_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic stop_pixels();
		pixel_valid <= 1'b0;
	endtask

	// Receiving side: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				record_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				longest_hold = HOLD_CYCLES;
				holds_served++;
			end else if (!calm && stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
				record_ready <= 1'b0;
				repeat ($urandom_range(0, 13)) @(negedge clk);
			end else begin
				record_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_ports
		rec_t  got;
		rec_t  want;
		string bad;
		bit    moved;
		moved = 1'b0;
		if (arst_n && pixel_valid && pixel_ready) begin
			moved = 1'b1;
			pixels_taken++;
			plan_records({red, green, blue});
			if (typed_armed) begin
				foreach (typed_records[k]) pending_records.push_back(typed_records[k]);
			end else begin
				foreach (planned[k]) pending_records.push_back(planned[k]);
			end
		end
		if (arst_n && record_valid && record_ready) begin
			moved = 1'b1;
			records_seen++;
			got.kind = record_kind;
			got.down = tool_down;
			got.ox   = offset_x;
			got.oy   = offset_y;
			got.mx   = move_x;
			got.my   = move_y;
			got.mz   = move_z;
			got.last = last_of_pixel;
			if (pending_records.size() == 0) begin
				flag_mismatch($sformatf("record %0d arrived with nothing expected",
					records_seen));
			end else begin
				want = pending_records.pop_front();
				bad  = "";
				if (got.kind !== want.kind) bad = {bad, " record_kind"};
				if (got.down !== want.down) bad = {bad, " tool_down"};
				if (got.ox !== want.ox) bad = {bad, " offset_x"};
				if (got.oy !== want.oy) bad = {bad, " offset_y"};
				if (got.mx !== want.mx) bad = {bad, " move_x"};
				if (got.my !== want.my) bad = {bad, " move_y"};
				if (got.mz !== want.mz) bad = {bad, " move_z"};
				if (got.last !== want.last) bad = {bad, " last_of_pixel"};
				if (bad != "") begin
					flag_mismatch({$sformatf(
						"record %0d differs in%s: got %0d/%0d (%0d,%0d) [%0d,%0d,%0d] %0d",
						records_seen, bad, got.kind, got.down, got.ox, got.oy, got.mx,
						got.my, got.mz, got.last),
						$sformatf(", want %0d/%0d (%0d,%0d) [%0d,%0d,%0d] %0d",
						want.kind, want.down, want.ox, want.oy, want.mx, want.my,
						want.mz, want.last)});
				end
			end
		end
		if (arst_n) begin
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timed out: no item moved on either side for %0d cycles.",
					IDLE_LIMIT);
				$display("serpentine_raster_toolpath: mismatch");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [23:0] rgb;
		shadow_cfg = make_cfg(1'b0, RST_IMAGE_SIDE, RST_IMAGE_SIDE, 0, 0, RST_SCALE_CODE,
			RST_DEPTH_CODE);

		// Reset defaults: unit scale 1 mm per pixel, plunge of 1.1 mm.
		add_pixel_row(0, RGB_BLACK, 1, 2, exp_rec(KIND_TRACE, TOOL_DOWN, 0, 0, 0, 0, 0, 0),
			exp_rec(KIND_MOVE, TOOL_DOWN, 0, 0, 0, 0, -11000, 1));
		add_pixel_row(0, RGB_BLACK, 1, 1, exp_rec(KIND_TRACE, TOOL_DOWN, 1, 0, 0, 0, 0, 1),
			'0);
		add_pixel_row(0, RGB_RED, 1, 2, exp_rec(KIND_TRACE, TOOL_DOWN, 2, 0, 0, 0, 0, 0),
			exp_rec(KIND_MOVE, TOOL_DOWN, 2, 0, 20000, 0, -11000, 1));
		add_pixel_row(0, RGB_WHITE, 1, 1,
			exp_rec(KIND_MOVE, TOOL_UP, 3, 0, 30000, 0, 20000, 1), '0);
		add_pixel_row(0, RGB_WHITE, 1, 0, '0, '0);
		add_pixel_row(0, RGB_GREEN, 1, 2, exp_rec(KIND_TRACE, TOOL_DOWN, 5, 0, 0, 0, 0, 0),
			exp_rec(KIND_MOVE, TOOL_DOWN, 5, 0, 50000, 0, -11000, 1));
		add_pixel_row(0, RGB_BLUE, 1, 2, exp_rec(KIND_TRACE, TOOL_DOWN, 6, 0, 0, 0, 0, 0),
			exp_rec(KIND_MOVE, TOOL_DOWN, 6, 0, 60000, 0, -11000, 1));
		add_pixel_row(0, 24'h0000FE, 1, 1,
			exp_rec(KIND_MOVE, TOOL_UP, 7, 0, 70000, 0, 20000, 1), '0);
		add_pixel_row(0, 24'h010000, 1, 0, '0, '0);
		add_pixel_row(0, 24'h00FE00, 1, 0, '0, '0);
		// Tiny frame with far origin, out-of-range depth and the largest scale code.
		add_pixel_row(1, RGB_BLACK, 0, 0, '0, '0);
		add_pixel_row(0, RGB_BLACK, 0, 0, '0, '0);
		add_pixel_row(0, RGB_BLACK, 0, 0, '0, '0);
		add_pixel_row(0, 24'h804020, 0, 0, '0, '0);
		// Column scan with zero and oversized sides, zero scale and depth.
		add_pixel_row(2, RGB_BLUE, 0, 0, '0, '0);
		add_pixel_row(0, RGB_BLUE, 0, 0, '0, '0);
		add_pixel_row(0, RGB_BLACK, 0, 0, '0, '0);
		add_pixel_row(0, RGB_BLACK, 0, 0, '0, '0);
		// A one-pixel line brings the scan to the start of a reversed line,
		// which after widening begins at the far column.
		add_pixel_row(3, RGB_BLACK, 0, 0, '0, '0);
		add_pixel_row(0, RGB_BLACK, 0, 0, '0, '0);
		add_pixel_row(4, RGB_RED, 1, 2, exp_rec(KIND_TRACE, TOOL_DOWN, 1023, 1, 0, 0, 0, 0),
			exp_rec(KIND_MOVE, TOOL_DOWN, 1023, 1, 10230000, 10000, -31000, 1));
		add_pixel_row(0, RGB_WHITE, 1, 1,
			exp_rec(KIND_MOVE, TOOL_UP, 1022, 1, 10220000, 10000, 20000, 1), '0);
		add_pixel_row(0, RGB_BLACK, 0, 0, '0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_odds   = 3;
		stall_odds = 3;
		foreach (dir_rows[k]) begin
			if (dir_rows[k].preset != 3'd0) begin
				stop_pixels();
				program_when_idle(preset_cfg(dir_rows[k].preset));
			end
			typed_records.delete();
			if (dir_rows[k].typed && dir_rows[k].count >= 2'd1) begin
				typed_records.push_back(dir_rows[k].first);
			end
			if (dir_rows[k].typed && dir_rows[k].count == 2'd2) begin
				typed_records.push_back(dir_rows[k].second);
			end
			typed_armed = dir_rows[k].typed;
			offer_pixel(dir_rows[k].rgb);
		end
		stop_pixels();
		typed_armed = 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			calm       = (p >= PHASES - 2);
			gap_odds   = (calm || p == 3) ? 0 : $urandom_range(0, 4);
			stall_odds = calm ? 0 : $urandom_range(0, 4);
			program_when_idle(random_cfg());
			for (int i = 0; i < PER_PHASE; i++) begin
				if (p == 3 && i == 5) begin
					hold_requests++;
				end
				if (p == 6 && i == PER_PHASE / 2) begin
					stop_pixels();
					wait_drained();
					drains++;
				end
				rgb = pick_colour();
				offer_pixel(rgb);
			end
			stop_pixels();
		end

		while (pending_records.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Covered %0d pixels and %0d records over %0d register settings, %s",
			pixels_taken, records_seen, settings_done, "row and column scans alike.");
		$display("Output held off for %0d cycles while pixels kept coming; %0d mid-run drain.",
			longest_hold, drains);
		if (faults == 0) begin
			$display("serpentine_raster_toolpath: match");
		end else begin
			$display("serpentine_raster_toolpath: mismatch");
		end
		$finish;
	end

endmodule
